FILE: design/pse_pkg.sv
// Shared types and codes for the postfix stack evaluator.
package pse_pkg;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_OPER   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_DIVZERO   = 3'd2;
    localparam logic [2:0] ST_BADOP     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_LEFTOVER  = 3'd5;

    localparam logic [7:0] OP_ADD = 8'h2B;
    localparam logic [7:0] OP_SUB = 8'h2D;
    localparam logic [7:0] OP_MUL = 8'h2A;
    localparam logic [7:0] OP_DIV = 8'h2F;

    // controller -> datapath
    typedef struct packed {
        logic load_tok;   // latch incoming word
        logic rd_top;     // read stack[depth-1]
        logic rd_next;    // read stack[depth-2]
        logic cap_r;      // capture read data as right operand / top
        logic cap_l;      // capture read data as left operand
        logic mul_go;     // register the product
        logic div_start;  // start divider
        logic div_step;   // one divider iteration
        logic finish;     // compute result word
    } pse_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
    } pse_stat_t;

endpackage

FILE: design/pse_datapath.sv
// Datapath: operand stack memory, operand registers, multiplier, divider, result.
module pse_datapath #(
    parameter int STACK_DEPTH = 32,
    parameter int AW = 5,
    parameter int DW = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pse_pkg::pse_cmd_t cmd_i,
    output pse_pkg::pse_stat_t stat_o,
    input  logic [1:0]        tok_cmd,
    input  logic [31:0]       tok_val,
    input  logic [7:0]        tok_op,
    output logic [2:0]        res_status,
    output logic [31:0]       res_value,
    output logic              res_sat,
    output logic [5:0]        res_count
);
    import pse_pkg::*;

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rdata_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] val_reg;
    logic [7:0]  op_reg;
    logic [DW-1:0] depth_reg, depth_next;
    logic [31:0] r_reg, l_reg;
    logic [63:0] prod_reg;
    logic [48:0] rem_reg;
    logic [48:0] quo_reg;
    logic [5:0]  div_cnt_reg;
    logic [2:0]  status_next;
    logic [31:0] value_next;
    logic        sat_next;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;

    logic signed [32:0] l_s, r_s;
    logic signed [33:0] sum_w, dif_w;
    logic neg;
    logic [31:0] mag_l, mag_r;
    logic [47:0] mul_q;
    logic [48:0] div_q;

    assign rd_addr = cmd_i.rd_next ? AW'(depth_reg - DW'(2)) : AW'(depth_reg - DW'(1));

    always_ff @(posedge aclk) begin
        if (cmd_i.rd_top || cmd_i.rd_next) begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= value_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_tok) begin
            cmd_reg <= tok_cmd;
            val_reg <= tok_val;
            op_reg  <= tok_op;
        end
        if (cmd_i.cap_r) r_reg <= rdata_reg;
        if (cmd_i.cap_l) l_reg <= rdata_reg;
        if (cmd_i.mul_go) prod_reg <= {32'd0, mag_l} * {32'd0, mag_r};
    end

    always_comb begin
        l_s   = {l_reg[31], l_reg};
        r_s   = {r_reg[31], r_reg};
        sum_w = 34'(l_s) + 34'(r_s);
        dif_w = 34'(l_s) - 34'(r_s);
        neg   = l_reg[31] ^ r_reg[31];
        mag_l = l_reg[31] ? 32'(-l_reg) : l_reg;
        mag_r = r_reg[31] ? 32'(-r_reg) : r_reg;
        mul_q = 48'((prod_reg + 64'h8000) >> 16);
        div_q = quo_reg;
    end

    // restoring divide of (2n+d) by 2d; numerator fed one bit a step
    logic [49:0] div_num;
    assign div_num = {1'b0, mag_l, 17'd0} + {18'd0, mag_r};
    logic [49:0] rem_sh;
    logic [50:0] d2;
    assign d2 = {18'd0, mag_r, 1'b0};
    assign rem_sh = {rem_reg, div_num[6'd49 - div_cnt_reg]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd_i.div_start) begin
            div_cnt_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cmd_i.div_step) begin
            if ({1'b0, rem_sh} >= d2) begin
                rem_reg <= 49'({1'b0, rem_sh} - d2);
                quo_reg <= {quo_reg[47:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[48:0];
                quo_reg <= {quo_reg[47:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 6'd1;
        end
    end
    assign stat_o.div_done = (div_cnt_reg == 6'd50);

    function automatic logic [32:0] from_mag(input logic n, input logic [48:0] q);
        if (!n) return (q > 49'h7FFFFFFF) ? {1'b1, 32'h7FFFFFFF} : {1'b0, q[31:0]};
        return (q > 49'h80000000) ? {1'b1, 32'h80000000} : {1'b0, 32'(-q[31:0])};
    endfunction

    logic [32:0] fm;
    always_comb begin
        status_next = ST_OK;
        value_next  = '0;
        sat_next    = 1'b0;
        depth_next  = depth_reg;
        wr_en       = 1'b0;
        wr_addr     = AW'(depth_reg);
        fm          = '0;
        unique case (cmd_reg)
            CMD_PUSH: begin
                if (depth_reg >= DW'(STACK_DEPTH)) begin
                    status_next = ST_OVERFLOW;
                    depth_next  = '0;
                end else begin
                    value_next = val_reg;
                    wr_en      = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
            end
            CMD_OPER: begin
                if (depth_reg < DW'(2)) begin
                    status_next = ST_UNDERFLOW;
                    depth_next  = '0;
                end else begin
                    wr_addr = AW'(depth_reg - DW'(2));
                    case (op_reg)
                        OP_ADD: begin
                            sat_next = (sum_w > 34'sh7FFFFFFF) || (sum_w < -34'sh80000000);
                            value_next = sum_w > 34'sh7FFFFFFF ? 32'h7FFFFFFF :
                                sum_w < -34'sh80000000 ? 32'h80000000 : sum_w[31:0];
                        end
                        OP_SUB: begin
                            sat_next = (dif_w > 34'sh7FFFFFFF) || (dif_w < -34'sh80000000);
                            value_next = dif_w > 34'sh7FFFFFFF ? 32'h7FFFFFFF :
                                dif_w < -34'sh80000000 ? 32'h80000000 : dif_w[31:0];
                        end
                        OP_MUL: begin
                            fm = from_mag(neg, {1'b0, mul_q});
                            value_next = fm[31:0];
                            sat_next   = fm[32];
                        end
                        OP_DIV: begin
                            if (r_reg == '0) status_next = ST_DIVZERO;
                            else begin
                                fm = from_mag(neg, div_q);
                                value_next = fm[31:0];
                                sat_next   = fm[32];
                            end
                        end
                        default: status_next = ST_BADOP;
                    endcase
                    if (status_next != ST_OK) begin
                        value_next = '0;
                        sat_next   = 1'b0;
                        depth_next = '0;
                    end else begin
                        wr_en      = 1'b1;
                        depth_next = depth_reg - DW'(1);
                    end
                end
            end
            CMD_FINISH: begin
                if (depth_reg == '0) begin
                    status_next = ST_UNDERFLOW;
                    depth_next  = '0;
                end else begin
                    value_next = r_reg;
                    depth_next = '0;
                    if (depth_reg != DW'(1)) status_next = ST_LEFTOVER;
                end
            end
            default: begin
                if (depth_reg != '0) value_next = r_reg;
            end
        endcase
        if (!cmd_i.finish) wr_en = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else if (cmd_i.finish) begin
            depth_reg  <= depth_next;
            res_status <= status_next;
            res_value  <= value_next;
            res_sat    <= sat_next;
            res_count  <= 6'(depth_next);
        end
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH)) else $error("stack depth over bound");
    a_no_wr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd_i.finish |-> !wr_en) else $error("stack write outside finish");
    a_div_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        div_cnt_reg <= 6'd50) else $error("divider count overrun");
`endif
endmodule

FILE: design/pse_ctrl.sv
// Controller state machine sequencing each token through the datapath.
module pse_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_cmd,
    input  logic [7:0]         in_op,
    output logic               out_valid,
    input  logic               out_ready,
    output pse_pkg::pse_cmd_t  cmd_o,
    input  pse_pkg::pse_stat_t stat_i
);
    import pse_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDT  = 3'd1;
    localparam logic [2:0] S_RDN  = 3'd2;
    localparam logic [2:0] S_CAPL = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] c_reg;
    logic [7:0] o_reg;
    logic       ov_reg, ov_next;

    // a new token may start while the previous result waits, as long as
    // it finishes only after that word is taken
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_comb begin
        cmd_o      = '0;
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        unique case (state_reg)
            S_IDLE: if (in_valid) begin
                cmd_o.load_tok = 1'b1;
                cmd_o.rd_top   = 1'b1;
                state_next     = S_RDT;
            end
            S_RDT: begin
                // top read data is ready; next-below read issues this cycle
                cmd_o.cap_r   = 1'b1;
                cmd_o.rd_next = 1'b1;
                state_next    = S_RDN;
            end
            S_RDN: begin
                state_next  = S_CAPL;
            end
            S_CAPL: begin
                cmd_o.cap_l = 1'b1;
                if (c_reg == CMD_OPER && o_reg == OP_MUL) state_next = S_MUL;
                else if (c_reg == CMD_OPER && o_reg == OP_DIV) state_next = S_DIV;
                else state_next = S_FIN;
                cmd_o.div_start = 1'b1;
            end
            S_MUL: begin
                cmd_o.mul_go = 1'b1;
                state_next   = S_FIN;
            end
            S_DIV: begin
                if (stat_i.div_done) state_next = S_FIN;
                else cmd_o.div_step = 1'b1;
            end
            S_FIN: if (!ov_reg || out_ready) begin
                cmd_o.finish = 1'b1;
                ov_next      = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        if (cmd_o.load_tok) begin
            c_reg <= in_cmd;
            o_reg <= in_op;
        end
    end

`ifndef SYNTHESIS
    a_one_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.finish |=> out_valid) else $error("result not shown");
    a_no_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |-> !cmd_o.finish) else $error("result overwritten");
    a_div_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.div_step |-> state_reg == S_DIV) else $error("stray divide step");
`endif
endmodule

FILE: design/postfix_stack_evaluator_unit.sv
// Top level of the postfix stack evaluator.
// Evaluates RPN tokens on a Q16.16 operand stack of STACK_DEPTH entries.
// s_axis: one token word per accept. tdata = operand_value, operator_char
//   from bit 0 up; tuser = cmd (0 push, 1 operator, 2 finish).
// m_axis: one status word per token. tdata = status, result_value,
//   saturated, stack_count from bit 0 up, zero filled to 48 bits.
// After it is accepted, each token steps through top read, next read, operand
// capture and finish; * adds a product register step and / a divider loop,
// retiring one quotient bit a cycle over a 50-bit numerator.
// One token is in work at a time; the next is taken once the current
// result is in the output register, even while that word waits.
// The stack memory is read through a registered port, two reads per token.
// Reset empties the stack and drops any pending result. A stalled m_axis
// holds the result and the next token waits in the final step.
module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // operand_value[31:0], operator_char[39:32]
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status[2:0], result_value[34:3], saturated[35], stack_count[41:36]
);
    import pse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    pse_cmd_t  cmd;
    pse_stat_t stat;
    logic [2:0]  st;
    logic [31:0] val;
    logic        sat;
    logic [5:0]  cnt;

    pse_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_cmd(s_axis_tuser), .in_op(s_axis_tdata[39:32]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd_o(cmd), .stat_i(stat)
    );

    pse_datapath #(.STACK_DEPTH(STACK_DEPTH), .AW(AW), .DW(DW)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd_i(cmd), .stat_o(stat),
        .tok_cmd(s_axis_tuser), .tok_val(s_axis_tdata[31:0]),
        .tok_op(s_axis_tdata[39:32]),
        .res_status(st), .res_value(val), .res_sat(sat), .res_count(cnt)
    );

    assign m_axis_tdata = {6'd0, cnt, sat, val, st};
endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the postfix stack evaluator unit.
module testbench;
    import pse_pkg::*;

    localparam int DEPTH = 32;
    localparam int IDLE_OFF = 750;   // words sent before idling stops
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    typedef struct packed {
        logic [5:0]  count;
        logic        sat;
        logic [31:0] value;
        logic [2:0]  status;
    } status_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    postfix_stack_evaluator_unit #(.STACK_DEPTH(DEPTH)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [31:0]  calc_stack [DEPTH];
    int           calc_depth;
    status_word_t status_queue [$];
    int           errors;
    int           words_sent;
    int           words_checked;
    bit           idle_en;
    int           n_ops [4];
    int           n_status [6];

    function automatic logic [31:0] sat_from_mag(bit neg, logic [63:0] q, ref logic sat);
        if (!neg) begin
            if (q > 64'h7FFF_FFFF) begin sat = 1'b1; return 32'h7FFF_FFFF; end
            return q[31:0];
        end
        if (q > 64'h8000_0000) begin sat = 1'b1; return 32'h8000_0000; end
        return 32'(-q);
    endfunction

    function automatic logic [31:0] sat_wide(longint v, ref logic sat);
        if (v > 64'sh7FFF_FFFF) begin sat = 1'b1; return 32'h7FFF_FFFF; end
        if (v < -64'sh8000_0000) begin sat = 1'b1; return 32'h8000_0000; end
        return v[31:0];
    endfunction

    function automatic status_word_t evaluate_token(logic [1:0] cmd, logic [31:0] val,
                                                    logic [7:0] op);
        status_word_t w;
        longint l, r;
        logic [63:0] ml, mr, q;
        bit neg;
        logic sat;
        w = '0;
        sat = 1'b0;
        if (cmd == CMD_PUSH) begin
            if (calc_depth >= DEPTH) begin
                w.status = ST_OVERFLOW;
                calc_depth = 0;
            end else begin
                calc_stack[calc_depth] = val;
                calc_depth++;
                w.value = val;
            end
        end else if (cmd == CMD_OPER) begin
            if (calc_depth < 2) begin
                w.status = ST_UNDERFLOW;
                calc_depth = 0;
            end else begin
                r = longint'($signed(calc_stack[calc_depth-1]));
                l = longint'($signed(calc_stack[calc_depth-2]));
                neg = (l < 0) != (r < 0);
                ml = (l < 0) ? -l : l;
                mr = (r < 0) ? -r : r;
                calc_depth -= 2;
                case (op)
                    OP_ADD: w.value = sat_wide(l + r, sat);
                    OP_SUB: w.value = sat_wide(l - r, sat);
                    OP_MUL: begin
                        q = (ml * mr + 64'h8000) >> 16;
                        w.value = sat_from_mag(neg, q, sat);
                    end
                    OP_DIV: begin
                        if (r == 0) w.status = ST_DIVZERO;
                        else begin
                            q = (2 * (ml << 16) + mr) / (2 * mr);
                            w.value = sat_from_mag(neg, q, sat);
                        end
                    end
                    default: w.status = ST_BADOP;
                endcase
                if (w.status != ST_OK) begin
                    w.value = '0;
                    sat = 1'b0;
                    calc_depth = 0;
                end else begin
                    calc_stack[calc_depth] = w.value;
                    calc_depth++;
                end
            end
        end else if (cmd == CMD_FINISH) begin
            if (calc_depth == 0) w.status = ST_UNDERFLOW;
            else begin
                calc_depth--;
                w.value = calc_stack[calc_depth];
                if (calc_depth != 0) begin
                    w.status = ST_LEFTOVER;
                    calc_depth = 0;
                end
            end
        end else if (calc_depth > 0) begin
            w.value = calc_stack[calc_depth-1];
        end
        w.sat = sat;
        w.count = 6'(calc_depth);
        return w;
    endfunction

    // tvalid stays high between back-to-back words and drops only for idling
    task automatic send_token(logic [1:0] cmd, logic [31:0] val, logic [7:0] op);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {op, val};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        status_queue.push_back(evaluate_token(cmd, val, op));
        n_ops[cmd]++;
        words_sent++;
        if (words_sent == IDLE_OFF) idle_en = 1'b0;
    endtask

    // result checker
    always @(posedge aclk) begin
        status_word_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[41:0];
            if (status_queue.size() == 0) begin
                $error("unexpected result word %h", m_axis_tdata);
                errors++;
            end else begin
                want = status_queue.pop_front();
                words_checked++;
                if (want.status <= ST_LEFTOVER) n_status[want.status]++;
                if (got.status !== want.status) begin
                    $error("status: expected %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.value !== want.value) begin
                    $error("result_value: expected %h got %h", want.value, got.value);
                    errors++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturated: expected %0d got %0d", want.sat, got.sat);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $error("stack_count: expected %0d got %0d", want.count, got.count);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0: return OP_ADD;
            1: return OP_SUB;
            2: return OP_MUL;
            default: return OP_DIV;
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 8)) - 4) <<< 16;
            3: return 32'(int'($urandom_range(0, 65535)) - 32768);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_token(CMD_FINISH, '0, '0);                       // finish on empty
        send_token(CMD_OPER, '0, OP_ADD);                     // underflow
        send_token(CMD_PUSH, 32'h7FFF_FFFF, '0);
        send_token(CMD_PUSH, 32'h7FFF_FFFF, '0);
        send_token(CMD_OPER, '0, OP_ADD);                     // positive clamp
        send_token(CMD_PUSH, 32'h8000_0000, '0);
        send_token(CMD_OPER, '0, OP_SUB);
        send_token(CMD_PUSH, 32'h0001_8000, '0);
        send_token(CMD_OPER, '0, OP_MUL);
        send_token(CMD_PUSH, 32'h0000_0000, '0);
        send_token(CMD_OPER, '0, OP_DIV);                     // divide by zero
        send_token(CMD_PUSH, 32'h8000_0000, '0);
        send_token(CMD_PUSH, 32'hFFFF_0000, '0);
        send_token(CMD_OPER, '0, OP_DIV);                     // most negative / -1
        send_token(CMD_PUSH, 32'h0003_0000, '0);
        send_token(CMD_OPER, '0, 8'hFF);                      // unsupported operator
        send_token(CMD_IGNORED, 32'hFFFF_FFFF, 8'hFF);        // unused command, empty
        send_token(CMD_PUSH, 32'h0000_0001, '0);
        send_token(CMD_IGNORED, '0, '0);                      // unused command, top
        send_token(CMD_PUSH, 32'h0002_0000, '0);
        send_token(CMD_FINISH, '0, '0);                       // leftover
        send_token(CMD_PUSH, 32'hFFFF_FFFF, '0);
        send_token(CMD_FINISH, '0, '0);
    endtask

    task automatic test_overflow();
        for (int i = 0; i <= DEPTH; i++) send_token(CMD_PUSH, $urandom(), 8'($urandom()));
        for (int i = 0; i < DEPTH; i++) send_token(CMD_PUSH, pick_value(), '0);
        for (int i = 0; i < DEPTH - 1; i++) send_token(CMD_OPER, '0, pick_op());
        send_token(CMD_FINISH, '0, '0);
    endtask

    task automatic test_random_expressions();
        int n;
        while (words_sent < 900) begin
            if ($urandom_range(0, 9) < 8) begin
                // well-formed expression with random content
                send_token(CMD_PUSH, pick_value(), 8'($urandom()));
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    send_token(CMD_PUSH, pick_value(), 8'($urandom()));
                    send_token(CMD_OPER, $urandom(), pick_op());
                end
                send_token(CMD_FINISH, $urandom(), 8'($urandom()));
            end else begin
                send_token(2'($urandom()), $urandom(),
                           $urandom_range(0, 1) ? pick_op() : 8'($urandom()));
            end
        end
    endtask

    initial begin
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        idle_en = 1'b1;
        calc_depth = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        test_random_expressions();
        s_axis_tvalid <= 1'b0;
        while (status_queue.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (status_queue.size() != 0) errors++;
        $display("Sent %0d tokens (push %0d, operator %0d, finish %0d), checked %0d words",
                 words_sent, n_ops[0], n_ops[1], n_ops[2], words_checked);
        $display("Status counts ok/under/div0/badop/over/left: %0d %0d %0d %0d %0d %0d",
                 n_status[0], n_status[1], n_status[2], n_status[3], n_status[4], n_status[5]);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
